// ===== rtl/core/gf2_innovative_vector_check_top_defines.svh =====
// Assertion macros shared by the GF(2) innovative vector check RTL.
`ifndef GF2_INNOVATIVE_VECTOR_CHECK_TOP_DEFINES_SVH
`define GF2_INNOVATIVE_VECTOR_CHECK_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define GVC_ASSERT_IMM(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gvc check failed");
`define GVC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gvc check failed");
`else
`define GVC_ASSERT_IMM(label, ante, cons)
`define GVC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== rtl/core/gvc_pkg.sv =====
// Package with item types, microcode types and the microcode table.
package gvc_pkg;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  receiver;
    logic [39:0] coeff_vector;
  } gvc_req_t;

  typedef struct packed {
    logic       innovative;
    logic [5:0] rank_now;
    logic       full_res;
  } gvc_res_t;

  typedef enum logic [2:0] {
    S_INIT  = 3'd0,
    S_IDLE  = 3'd1,
    S_CHECK = 3'd2,
    S_LOAD  = 3'd3,
    S_LOOP  = 3'd4,
    S_STORE = 3'd5,
    S_CLEAR = 3'd6,
    S_RESP  = 3'd7
  } gvc_step_t;

  typedef enum logic [2:0] {
    C_NEVER  = 3'd0,
    C_ALWAYS = 3'd1,
    C_WAIT   = 3'd2,
    C_SWEEP  = 3'd3,
    C_OOR    = 3'd4,
    C_CLEAR  = 3'd5,
    C_LOOP   = 3'd6
  } gvc_cond_t;

  typedef struct packed {
    logic      idle;
    logic      sweep;
    logic      meta_rd;
    logic      meta_ld;
    logic      meta_clr;
    logic      row_first;
    logic      row_step;
    logic      store;
    logic      resp;
    gvc_cond_t cond;
    gvc_step_t target;
  } gvc_ctrl_t;

  typedef struct packed {
    logic sweep_more;
    logic oor;
    logic clear;
    logic p_nz;
  } gvc_stat_t;

  function automatic gvc_ctrl_t gvc_ucode(gvc_step_t s);
    gvc_ctrl_t c;
    c = '0;
    unique case (s)
      S_INIT: begin
        c.sweep = 1'b1;
        c.cond = C_SWEEP;
        c.target = S_INIT;
      end
      S_IDLE: begin
        c.idle = 1'b1;
        c.cond = C_WAIT;
        c.target = S_IDLE;
      end
      S_CHECK: begin
        c.meta_rd = 1'b1;
        c.cond = C_OOR;
        c.target = S_RESP;
      end
      S_LOAD: begin
        c.meta_ld = 1'b1;
        c.row_first = 1'b1;
        c.cond = C_CLEAR;
        c.target = S_CLEAR;
      end
      S_LOOP: begin
        c.row_step = 1'b1;
        c.cond = C_LOOP;
        c.target = S_LOOP;
      end
      S_STORE: begin
        c.store = 1'b1;
        c.cond = C_ALWAYS;
        c.target = S_RESP;
      end
      S_CLEAR: begin
        c.meta_clr = 1'b1;
        c.cond = C_NEVER;
        c.target = S_RESP;
      end
      S_RESP: begin
        c.resp = 1'b1;
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
      default: begin
        c.cond = C_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/gvc_ram.sv =====
// Generic single-port-write, registered-read RAM.
module gvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/gvc_seq.sv =====
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module gvc_seq
  import gvc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  gvc_stat_t stat,
  output gvc_ctrl_t ctrl
);

  gvc_step_t step;
  gvc_step_t step_next;
  logic      take;

  always_comb begin
    ctrl = gvc_ucode(step);
  end

  always_comb begin
    unique case (ctrl.cond)
      C_NEVER:  take = 1'b0;
      C_ALWAYS: take = 1'b1;
      C_WAIT:   take = !start;
      C_SWEEP:  take = stat.sweep_more;
      C_OOR:    take = stat.oor;
      C_CLEAR:  take = stat.clear;
      C_LOOP:   take = stat.p_nz;
      default:  take = 1'b1;
    endcase
    step_next = take ? ctrl.target : gvc_step_t'(3'(step + 3'd1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_INIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/core/gvc_dp.sv =====
// Datapath: basis and pivot memories, elimination registers and result register.
`include "gf2_innovative_vector_check_top_defines.svh"
module gvc_dp
  import gvc_pkg::*;
#(
  parameter int VECTOR_BITS = 40,
  parameter int RECEIVERS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  gvc_req_t  cmd,
  input  gvc_ctrl_t ctrl,
  output gvc_stat_t stat,
  output logic      done,
  output gvc_res_t  result
);

  localparam int VW = VECTOR_BITS;
  localparam int RW = (RECEIVERS > 1) ? $clog2(RECEIVERS) : 1;
  localparam int PW = $clog2(VW);
  localparam int RKW = $clog2(VW + 1);
  localparam int MW = VW + RKW;
  localparam int AWR = $clog2(RECEIVERS * VW);

  logic           accept;
  logic           req_clear;
  logic           oor;
  logic [RW-1:0]  rx;
  logic [VW-1:0]  vec;
  logic [VW-1:0]  valid;
  logic [RKW-1:0] rank;
  logic [PW-1:0]  p;
  logic           found;
  logic [PW-1:0]  pivot;
  logic           innov;
  logic [RW-1:0]  sweep_cnt;
  logic [63:0]    cv_wide;
  logic           do_store;
  logic [VW-1:0]  vec_x;
  logic [AWR-1:0] row_base;
  logic [AWR-1:0] row_raddr;
  logic [AWR-1:0] row_waddr;
  logic           row_re;
  logic [VW-1:0]  row_rdata;
  logic           meta_we;
  logic [RW-1:0]  meta_waddr;
  logic [MW-1:0]  meta_wdata;
  logic [MW-1:0]  meta_rdata;
  logic [5:0]     rank_sat;

  assign accept = start && ctrl.idle;
  assign cv_wide = 64'(cmd.coeff_vector);
  assign do_store = found && (rank < RKW'(VW));

  assign stat.sweep_more = sweep_cnt != RW'(RECEIVERS - 1);
  assign stat.oor = oor;
  assign stat.clear = req_clear;
  assign stat.p_nz = p != '0;

  assign row_base = AWR'(rx) * AWR'(VW);
  assign row_raddr = row_base + AWR'(ctrl.row_first ? PW'(VW - 1) : PW'(p - 1'b1));
  assign row_waddr = row_base + AWR'(pivot);
  assign row_re = ctrl.row_first || (ctrl.row_step && stat.p_nz);

  assign vec_x = (vec[p] && valid[p]) ? (vec ^ row_rdata) : vec;

  assign meta_we = ctrl.sweep || ctrl.meta_clr || (ctrl.store && do_store);
  assign meta_waddr = ctrl.sweep ? sweep_cnt : rx;
  assign meta_wdata = (ctrl.sweep || ctrl.meta_clr) ? '0
                    : {valid | (VW'(1) << pivot), RKW'(rank + 1'b1)};

  assign rank_sat = (rank > RKW'(63)) ? 6'd63 : 6'(rank);

  gvc_ram #(.WIDTH(VW), .DEPTH(RECEIVERS * VW)) u_rows (
    .clk   (clk),
    .we    (ctrl.store && do_store),
    .waddr (row_waddr),
    .wdata (vec),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  gvc_ram #(.WIDTH(MW), .DEPTH(RECEIVERS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (ctrl.meta_rd),
    .raddr (rx),
    .rdata (meta_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      done <= 1'b0;
    end else begin
      if (ctrl.sweep) begin
        sweep_cnt <= RW'(sweep_cnt + 1'b1);
      end
      done <= ctrl.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_clear <= cmd.req_type;
      rx <= RW'(cmd.receiver);
      oor <= 7'(cmd.receiver) >= 7'(RECEIVERS);
      vec <= cv_wide[VW-1:0];
      rank <= '0;
      found <= 1'b0;
      innov <= 1'b0;
    end
    if (ctrl.meta_ld) begin
      valid <= meta_rdata[MW-1:RKW];
      rank <= meta_rdata[RKW-1:0];
    end
    if (ctrl.row_first) begin
      p <= PW'(VW - 1);
    end
    if (ctrl.row_step) begin
      vec <= vec_x;
      p <= PW'(p - 1'b1);
      if (!found && vec_x[p]) begin
        found <= 1'b1;
        pivot <= p;
      end
    end
    if (ctrl.store && do_store) begin
      rank <= RKW'(rank + 1'b1);
      innov <= 1'b1;
    end
    if (ctrl.meta_clr) begin
      rank <= '0;
    end
    if (ctrl.resp) begin
      result.innovative <= innov;
      result.rank_now <= rank_sat;
      result.full_res <= rank == RKW'(VW);
    end
  end

  `GVC_ASSERT_NXT(a_done_single, done, !done)
  `GVC_ASSERT_IMM(a_pivot_free, ctrl.store && do_store, !valid[pivot])
  `GVC_ASSERT_IMM(a_oor_zero, ctrl.resp && oor, rank == '0 && !innov)

endmodule

// ===== rtl/core/gf2_innovative_vector_check_top.sv =====
// Top level of the GF(2) innovative vector check with one basis per receiver.
//
// An item is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and must be taken
// then, since the receiver cannot hold results off. An offer goes through
// the check, load, elimination loop, store and response steps; the loop
// reads one stored pivot row per cycle from the basis memory. A clear item
// takes the clear step in place of the loop, and an item naming a receiver
// at or above RECEIVERS goes from the check straight to the response. After
// reset the per-receiver pivot memory is swept, busy high, before any item.
module gf2_innovative_vector_check_top
  import gvc_pkg::*;
#(
  parameter int VECTOR_BITS = 40,
  parameter int RECEIVERS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  gvc_req_t cmd,
  output logic     busy,
  output logic     done,
  output gvc_res_t result
);

  gvc_ctrl_t ctrl;
  gvc_stat_t stat;

  assign busy = !ctrl.idle;

  gvc_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  gvc_dp #(.VECTOR_BITS(VECTOR_BITS), .RECEIVERS(RECEIVERS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .ctrl   (ctrl),
    .stat   (stat),
    .done   (done),
    .result (result)
  );

endmodule

// ===== bench/gf2_innovative_vector_check_top_tb.sv =====
// Self-checking testbench for the GF(2) innovative vector check top level.
`timescale 1ns / 1ps

module gf2_innovative_vector_check_top_tb;
  import gvc_pkg::*;

  localparam int VEC_BITS = 40;
  localparam int NUM_RX = 16;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  gvc_req_t cmd = '0;
  logic     busy;
  logic     done;
  gvc_res_t result;

  gvc_req_t    pending_items[$];
  gvc_res_t    expected_results[$];
  logic [39:0] basis_rows[NUM_RX][VEC_BITS];
  logic [39:0] pivot_mask[NUM_RX];
  int          rank_held[NUM_RX];

  int errors = 0;
  int items_sent = 0;
  int offers_sent = 0;
  int clears_sent = 0;
  int innovative_seen = 0;
  int full_seen = 0;

  gf2_innovative_vector_check_top #(
    .VECTOR_BITS(VEC_BITS),
    .RECEIVERS(NUM_RX)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .done(done),
    .result(result)
  );

  always #5 clk = ~clk;

  function automatic gvc_res_t rank_update(gvc_req_t req);
    gvc_res_t    res;
    logic [39:0] rem;
    int          rx;
    bit          stored;
    res = '0;
    rx = req.receiver;
    stored = 1'b0;
    if (rx >= NUM_RX) begin
      return res;
    end
    if (req.req_type) begin
      pivot_mask[rx] = '0;
      rank_held[rx] = 0;
      return res;
    end
    rem = req.coeff_vector;
    for (int p = VEC_BITS - 1; p >= 0; p--) begin
      if (rem[p] && pivot_mask[rx][p]) begin
        rem = rem ^ basis_rows[rx][p];
      end
    end
    if (rem != '0 && rank_held[rx] < VEC_BITS) begin
      for (int p = VEC_BITS - 1; p >= 0; p--) begin
        if (!stored && rem[p]) begin
          basis_rows[rx][p] = rem;
          pivot_mask[rx][p] = 1'b1;
          rank_held[rx]++;
          res.innovative = 1'b1;
          stored = 1'b1;
        end
      end
    end
    res.rank_now = (rank_held[rx] > 63) ? 6'd63 : 6'(rank_held[rx]);
    res.full_res = (rank_held[rx] == VEC_BITS);
    return res;
  endfunction

  function automatic logic [39:0] rand_vec();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[39:0];
  endfunction

  task automatic add_item(logic kind, logic [3:0] rx, logic [39:0] vec);
    gvc_req_t req;
    req.req_type = kind;
    req.receiver = rx;
    req.coeff_vector = vec;
    pending_items.insert(pending_items.size(), req);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        gvc_res_t exp_res;
        exp_res = rank_update(cmd);
        expected_results.insert(expected_results.size(), exp_res);
        items_sent++;
        if (cmd.req_type) begin
          clears_sent++;
        end else begin
          offers_sent++;
          innovative_seen += exp_res.innovative;
          full_seen += exp_res.full_res;
        end
      end
      if (!start || !busy) begin
        if (pending_items.size() > 0 &&
            !((items_sent < 500 || items_sent >= 800) && $urandom_range(0, 99) < 17)) begin
          start <= 1'b1;
          cmd <= pending_items[0];
          pending_items.delete(0);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        errors++;
        $error("result with no item outstanding: %p", result);
      end else begin
        gvc_res_t exp_res;
        exp_res = expected_results[0];
        expected_results.delete(0);
        if (result.innovative !== exp_res.innovative) begin
          errors++;
          $error("innovative: expected %0d, got %0d", exp_res.innovative, result.innovative);
        end
        if (result.rank_now !== exp_res.rank_now) begin
          errors++;
          $error("rank_now: expected %0d, got %0d", exp_res.rank_now, result.rank_now);
        end
        if (result.full_res !== exp_res.full_res) begin
          errors++;
          $error("full_res: expected %0d, got %0d", exp_res.full_res, result.full_res);
        end
      end
    end
  end

  initial begin
    logic [39:0] seq_vecs[$];
    logic [39:0] vec;
    logic [3:0]  rx;
    int          count;
    int          seq_len;
    int          pick;
    for (int r = 0; r < NUM_RX; r++) begin
      pivot_mask[r] = '0;
      rank_held[r] = 0;
    end

    add_item(1'b0, 4'd0, 40'h0);
    add_item(1'b0, 4'd15, 40'hFF_FFFF_FFFF);
    add_item(1'b0, 4'd15, 40'hFF_FFFF_FFFF);
    add_item(1'b0, 4'd15, 40'h80_0000_0000);
    add_item(1'b0, 4'd15, 40'h00_0000_0001);
    add_item(1'b0, 4'd15, 40'h7F_FFFF_FFFE);
    add_item(1'b1, 4'd15, 40'hFF_FFFF_FFFF);
    add_item(1'b0, 4'd15, 40'hFF_FFFF_FFFF);
    add_item(1'b1, 4'd0, 40'h0);
    add_item(1'b0, 4'd10, 40'hAA_AAAA_AAAA);
    add_item(1'b0, 4'd10, 40'h55_5555_5555);
    add_item(1'b0, 4'd10, 40'hFF_FFFF_FFFF);
    add_item(1'b0, 4'd10, 40'h00_0000_0000);
    add_item(1'b0, 4'd5, 40'h00_0000_0001);
    add_item(1'b0, 4'd5, 40'h00_0000_0001);
    add_item(1'b1, 4'd10, 40'h0);

    count = pending_items.size();
    while (count < 1350) begin
      pick = $urandom_range(0, 99);
      rx = 4'($urandom_range(0, NUM_RX - 1));
      if (pick < 70) begin
        seq_vecs.delete();
        seq_len = (pick < 25) ? $urandom_range(40, 48) : $urandom_range(1, 20);
        for (int i = 0; i < seq_len; i++) begin
          case ((pick < 25) ? (($urandom_range(0, 9) == 0) ? 1 : 0) : $urandom_range(0, 4))
            0: vec = rand_vec();
            1: vec = rand_vec() & 40'h00_0000_00FF;
            2: vec = (seq_vecs.size() >= 2) ?
                     seq_vecs[$urandom_range(0, seq_vecs.size() - 1)] ^
                     seq_vecs[$urandom_range(0, seq_vecs.size() - 1)] : rand_vec();
            3: vec = '0;
            default: vec = 40'h1 << $urandom_range(0, VEC_BITS - 1);
          endcase
          seq_vecs.insert(seq_vecs.size(), vec);
          add_item(1'b0, rx, vec);
        end
        count += seq_len;
        if ($urandom_range(0, 1) == 1) begin
          add_item(1'b1, rx, rand_vec());
          count++;
        end
      end else begin
        add_item(1'($urandom_range(0, 1)), rx, rand_vec());
        count++;
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $error("%0d results never arrived", expected_results.size());
    end

    $display("Covered %0d items: %0d offers, %0d of them innovative, %0d at full rank,",
             items_sent, offers_sent, innovative_seen, full_seen);
    $display("and %0d clears; %0d check failures.", clears_sent, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gvc_pkg.sv
rtl/core/gvc_ram.sv
rtl/core/gvc_seq.sv
rtl/core/gvc_dp.sv
rtl/core/gf2_innovative_vector_check_top.sv
bench/gf2_innovative_vector_check_top_tb.sv
